// ===== design/blad_pkg.sv =====
// ----------------------------------------------------------------------------
// blad_pkg
// Shared types and constants for the bounded append/delete list.
// ----------------------------------------------------------------------------
package blad_pkg;

  localparam int DEFAULT_LIST_DEPTH = 16;
  localparam int KEY_W              = 32;
  localparam int TOTAL_W            = 32;
  localparam int OUT_CNT_W          = 5;

  typedef enum logic {
    MODE_APPEND = 1'b0,
    MODE_DELETE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_APPENDED  = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_REMOVED   = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_t;

  // Per-cell control from the list controller.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== design/blad_cell.sv =====
// ----------------------------------------------------------------------------
// blad_cell
// One list slot: holds an entry, loads a new key or takes its neighbour's.
// ----------------------------------------------------------------------------
module blad_cell (
  input  logic                      clk,
  input  blad_pkg::cell_ctrl_t      ctrl,
  input  logic [blad_pkg::KEY_W-1:0] load_data,
  input  logic [blad_pkg::KEY_W-1:0] next_data,
  output logic [blad_pkg::KEY_W-1:0] data_q
);
  import blad_pkg::*;

  logic [KEY_W-1:0] data_r;
  logic [KEY_W-1:0] data_nxt;

  // A load wins over the shift, so the tail slot can take the recirculated head.
  always_comb begin
    priority if (ctrl.load) begin
      data_nxt = load_data;
    end else if (ctrl.shift) begin
      data_nxt = next_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== design/bounded_list_append_delete.sv =====
// ----------------------------------------------------------------------------
// bounded_list_append_delete
// Ordered list of signed keys held in a chain of cells, with append at the
// tail and delete of every matching entry, plus saturating event totals.
//
//   Channel   Handshake          Payload
//   -------   ----------------   ---------------------------------------------
//   input     start / busy       in_mode, in_key
//   result    out_valid strobe   out_status, out_removed_count, out_occupancy,
//                                out_append_total, out_removal_total
//
// An append's result is registered and appears in the following cycle.
// A delete sweeps the held entries once through the chain, one entry per
// cycle; on an empty list it reports not-found without a sweep.
// During the sweep busy is high and start is ignored. Reset is synchronous
// and active low and empties the list. The receiver cannot stall: each
// result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module bounded_list_append_delete #(
  parameter int LIST_DEPTH = blad_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic signed [blad_pkg::KEY_W-1:0] in_key,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [blad_pkg::OUT_CNT_W-1:0] out_removed_count,
  output logic [blad_pkg::OUT_CNT_W-1:0] out_occupancy,
  output logic [blad_pkg::TOTAL_W-1:0]  out_append_total,
  output logic [blad_pkg::TOTAL_W-1:0]  out_removal_total
);
  import blad_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    step_r, step_nxt;
  logic [CW-1:0]    removed_r, removed_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [TOTAL_W-1:0] app_tot_r, app_tot_nxt;
  logic [TOTAL_W-1:0] rem_tot_r, rem_tot_nxt;
  logic             vld_r, vld_nxt;
  status_t          status_r, status_nxt;
  logic [CW-1:0]    res_removed_r, res_removed_nxt;

  logic             shift_en;
  logic             load_en;
  logic [CW-1:0]    wpos;
  logic [KEY_W-1:0] load_data;
  logic [KEY_W-1:0] cell_q [LIST_DEPTH];
  logic             head_match;
  logic [TOTAL_W:0] rem_sum;

  assign head_match = (cell_q[0] == key_r);
  // On the last sweep cycle the new total adds the running count and this head.
  assign rem_sum    = {1'b0, rem_tot_r} + (TOTAL_W + 1)'(removed_r)
                      + (TOTAL_W + 1)'(head_match);

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    step_nxt        = step_r;
    removed_nxt     = removed_r;
    key_nxt         = key_r;
    app_tot_nxt     = app_tot_r;
    rem_tot_nxt     = rem_tot_r;
    vld_nxt         = 1'b0;
    status_nxt      = status_r;
    res_removed_nxt = res_removed_r;
    shift_en        = 1'b0;
    load_en         = 1'b0;
    wpos            = fill_r;
    load_data       = in_key;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_APPEND) begin
            vld_nxt         = 1'b1;
            res_removed_nxt = '0;
            if (fill_r < CW'(LIST_DEPTH)) begin
              load_en    = 1'b1;
              fill_nxt   = fill_r + CW'(1);
              status_nxt = STATUS_APPENDED;
              if (app_tot_r != '1) begin
                app_tot_nxt = app_tot_r + TOTAL_W'(1);
              end
            end else begin
              status_nxt = STATUS_FULL;
            end
          end else begin
            key_nxt     = in_key;
            removed_nxt = '0;
            if (fill_r == '0) begin
              vld_nxt         = 1'b1;
              res_removed_nxt = '0;
              status_nxt      = STATUS_NOT_FOUND;
            end else begin
              step_nxt  = fill_r;
              state_nxt = ST_SWEEP;
            end
          end
        end
      end
      ST_SWEEP: begin
        // The head leaves cell 0 each cycle; a kept entry rejoins at the tail,
        // so after one pass the survivors are back in their original order.
        shift_en  = 1'b1;
        load_data = cell_q[0];
        wpos      = fill_r - CW'(1);
        if (head_match) begin
          fill_nxt    = fill_r - CW'(1);
          removed_nxt = removed_r + CW'(1);
        end else begin
          load_en = 1'b1;
        end
        step_nxt = step_r - CW'(1);
        if (step_r == CW'(1)) begin
          state_nxt       = ST_IDLE;
          vld_nxt         = 1'b1;
          res_removed_nxt = removed_nxt;
          status_nxt      = (removed_nxt != '0) ? STATUS_REMOVED : STATUS_NOT_FOUND;
          rem_tot_nxt     = rem_sum[TOTAL_W] ? '1 : rem_sum[TOTAL_W-1:0];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      step_r    <= '0;
      removed_r <= '0;
      app_tot_r <= '0;
      rem_tot_r <= '0;
      vld_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      step_r    <= step_nxt;
      removed_r <= removed_nxt;
      app_tot_r <= app_tot_nxt;
      rem_tot_r <= rem_tot_nxt;
      vld_r     <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    status_r      <= status_nxt;
    res_removed_r <= res_removed_nxt;
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    cell_ctrl_t       ctrl;
    logic [KEY_W-1:0] nbr;

    assign ctrl.shift = shift_en;
    assign ctrl.load  = load_en && (wpos == CW'(i));

    if (i == LIST_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    blad_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_data (load_data),
      .next_data (nbr),
      .data_q    (cell_q[i])
    );
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = vld_r;
  assign out_status        = status_r;
  assign out_removed_count = OUT_CNT_W'(res_removed_r);
  assign out_occupancy     = OUT_CNT_W'(fill_r);
  assign out_append_total  = app_tot_r;
  assign out_removal_total = rem_tot_r;

endmodule

// ===== bench/bounded_list_append_delete_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_list_append_delete_tb
// Self-checking bench for the bounded append/delete list. Each transaction
// accepted on the start/busy channel is applied to a behavioural copy of the
// list, and the expected result is queued. Every out_valid strobe is checked
// field by field against the oldest queued result. Directed cases cover an
// empty list, filling to capacity, extreme keys and runs of adjacent matches.
// Random bursts with gaps of random length then follow, mixing fill-heavy
// and drain-heavy traffic.
// ----------------------------------------------------------------------------
module bounded_list_append_delete_tb;
  import blad_pkg::*;

  localparam int LIST_DEPTH   = DEFAULT_LIST_DEPTH;
  localparam int RANDOM_ITEMS = 880;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t                status;
    logic [OUT_CNT_W-1:0]   removed;
    logic [OUT_CNT_W-1:0]   occupancy;
    logic [TOTAL_W-1:0]     appends;
    logic [TOTAL_W-1:0]     removals;
  } list_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_mode;
  logic signed [KEY_W-1:0]     in_key;
  logic                        out_valid;
  logic [1:0]                  out_status;
  logic [OUT_CNT_W-1:0]        out_removed_count;
  logic [OUT_CNT_W-1:0]        out_occupancy;
  logic [TOTAL_W-1:0]          out_append_total;
  logic [TOTAL_W-1:0]          out_removal_total;

  // Behavioural copy of the list and its totals.
  logic signed [KEY_W-1:0]     list_keys [LIST_DEPTH];
  int                          list_fill;
  logic [TOTAL_W-1:0]          append_count;
  logic [TOTAL_W-1:0]          removal_count;

  list_result_t                results_due [$];
  list_result_t                oldest_due;
  int                          mismatch_count;
  logic signed [KEY_W-1:0]     key_pool [4];

  bounded_list_append_delete #(
    .LIST_DEPTH(LIST_DEPTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_occupancy     (out_occupancy),
    .out_append_total  (out_append_total),
    .out_removal_total (out_removal_total)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic list_result_t apply_list_op(mode_t op, logic signed [KEY_W-1:0] key);
    list_result_t res;
    int           hits;
    int           keep;
    logic [TOTAL_W:0] sum;
    res  = '0;
    hits = 0;
    keep = 0;
    if (op == MODE_APPEND) begin
      if (list_fill < LIST_DEPTH) begin
        list_keys[list_fill] = key;
        list_fill++;
        if (append_count != '1) append_count = append_count + TOTAL_W'(1);
        res.status = STATUS_APPENDED;
      end else begin
        res.status = STATUS_FULL;
      end
    end else begin
      // Compact the survivors in order; every match goes, adjacent ones too.
      for (int i = 0; i < list_fill; i++) begin
        if (list_keys[i] == key) begin
          hits++;
        end else begin
          list_keys[keep] = list_keys[i];
          keep++;
        end
      end
      for (int i = keep; i < LIST_DEPTH; i++) list_keys[i] = '0;
      list_fill     = keep;
      sum           = {1'b0, removal_count} + (TOTAL_W + 1)'(hits);
      removal_count = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      res.status    = (hits != 0) ? STATUS_REMOVED : STATUS_NOT_FOUND;
    end
    res.removed   = hits[OUT_CNT_W-1:0];
    res.occupancy = list_fill[OUT_CNT_W-1:0];
    res.appends   = append_count;
    res.removals  = removal_count;
    return res;
  endfunction

  task automatic note_failure(string what, logic [31:0] exp_val, logic [31:0] act_val);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected %0h, got %0h", $time, what, exp_val, act_val);
  endtask

  // Sends one transaction; start is left high so that a following send
  // can go out back to back.
  task automatic send_op(mode_t op, logic signed [KEY_W-1:0] key);
    if (!start) start <= 1'b1;
    in_mode <= op;
    in_key  <= key;
    do @(posedge clk); while (busy !== 1'b0);
    results_due.push_back(apply_list_op(op, key));
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (results_due.size() == 0) begin
        note_failure("result with nothing outstanding", 32'h0, {30'h0, out_status});
      end else begin
        oldest_due = results_due.pop_front();
        if (out_status !== oldest_due.status)
          note_failure("status", 32'(oldest_due.status), 32'(out_status));
        if (out_removed_count !== oldest_due.removed)
          note_failure("removed_count", 32'(oldest_due.removed), 32'(out_removed_count));
        if (out_occupancy !== oldest_due.occupancy)
          note_failure("occupancy", 32'(oldest_due.occupancy), 32'(out_occupancy));
        if (out_append_total !== oldest_due.appends)
          note_failure("append_total", oldest_due.appends, out_append_total);
        if (out_removal_total !== oldest_due.removals)
          note_failure("removal_total", oldest_due.removals, out_removal_total);
      end
    end
  end

  task automatic test_empty_delete();
    send_op(MODE_DELETE, 32'sd0);
    idle_cycles(2);
  endtask

  // Fills the list with extreme keys and a run of duplicates, then tries
  // one append too many.
  task automatic test_fill_to_full();
    send_op(MODE_APPEND, 32'sh8000_0000);
    send_op(MODE_APPEND, 32'sh7FFF_FFFF);
    send_op(MODE_APPEND, 32'sd0);
    send_op(MODE_APPEND, -32'sd1);
    send_op(MODE_APPEND, 32'sd5);
    send_op(MODE_APPEND, 32'sd5);
    send_op(MODE_APPEND, 32'sd5);
    send_op(MODE_APPEND, 32'sh5555_5555);
    send_op(MODE_APPEND, 32'shAAAA_AAAA);
    send_op(MODE_APPEND, 32'sd5);
    send_op(MODE_APPEND, 32'sd42);
    send_op(MODE_APPEND, -32'sd42);
    send_op(MODE_APPEND, 32'sd5);
    send_op(MODE_APPEND, 32'sd5);
    send_op(MODE_APPEND, 32'sh8000_0000);
    send_op(MODE_APPEND, 32'sd5);
    send_op(MODE_APPEND, 32'sd99);
  endtask

  task automatic test_delete_paths();
    // Full-length sweep with adjacent matches at several places.
    send_op(MODE_DELETE, 32'sd5);
    send_op(MODE_DELETE, 32'sh8000_0000);
    send_op(MODE_DELETE, 32'sh7FFF_FFFF);
    send_op(MODE_DELETE, 32'sd12345);
    wait_for_results();
  endtask

  task automatic refresh_key_pool();
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(1) == 0) key_pool[i] = int'($urandom_range(15)) - 8;
      else key_pool[i] = $urandom;
    end
  endtask

  task automatic test_random_traffic(int count);
    int    sent;
    int    burst;
    int    burst_len;
    int    append_pct;
    int    pick;
    mode_t op;
    logic signed [KEY_W-1:0] key;
    sent  = 0;
    burst = 0;
    refresh_key_pool();
    while (sent < count) begin
      burst_len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
      case ($urandom_range(2))
        0: append_pct = 85;
        1: append_pct = 55;
        default: append_pct = 30;
      endcase
      if ($urandom_range(3) == 0) refresh_key_pool();
      for (int n = 0; n < burst_len && sent < count; n++) begin
        op   = ($urandom_range(99) < append_pct) ? MODE_APPEND : MODE_DELETE;
        pick = $urandom_range(99);
        if (op == MODE_DELETE && list_fill > 0 && pick < 45)
          key = list_keys[$urandom_range(list_fill - 1)];
        else if (pick < 80)
          key = key_pool[$urandom_range(3)];
        else
          key = $urandom;
        send_op(op, key);
        sent++;
      end
      if (burst % 8 == 3) wait_for_results();
      else if ($urandom_range(4) != 0) idle_cycles($urandom_range(6, 1));
      burst++;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = 1'b0;
    in_key         = '0;
    mismatch_count = 0;
    list_fill      = 0;
    append_count   = '0;
    removal_count  = '0;
    for (int i = 0; i < LIST_DEPTH; i++) list_keys[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_delete();
    test_fill_to_full();
    test_delete_paths();
    test_random_traffic(RANDOM_ITEMS);

    wait_for_results();
    repeat (LIST_DEPTH + 4) @(posedge clk);
    mismatch_count += results_due.size();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
